/* src/pjq_pkg.sv */
`default_nettype none

package pjq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_POP   = 3'd1,
        FN_USER  = 3'd2,
        FN_CAP   = 3'd3,
        FN_LIST  = 3'd4,
        FN_CLEAR = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_PUT,
        S_POP_RD,
        S_POP_HEAD,
        S_POP_SH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0]        job_tag;
        logic [15:0]        user_tag;
        logic [7:0]         cpus;
        logic [7:0]         gpus;
        logic [15:0]        memory;
        logic [23:0]        run_time;
        logic signed [15:0] prio;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic lower;
    } t_match;

endpackage

`default_nettype wire

/* src/pjq_match.sv */
`default_nettype none

module pjq_match
    import pjq_pkg::*;
(
    input  var t_entry i_entry,
    input  var t_entry i_key,
    input  var t_func  i_func,
    output t_match     o_match
);

    always_comb begin
        o_match.lower = $signed(i_entry.prio) < $signed(i_key.prio);
        case (i_func)
            FN_USER: o_match.hit = (i_entry.user_tag == i_key.user_tag);
            FN_CAP:  o_match.hit = (i_entry.cpus == i_key.cpus)
                                && (i_entry.gpus == i_key.gpus)
                                && (i_entry.memory == i_key.memory)
                                && (i_entry.run_time == i_key.run_time);
            default: o_match.hit = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* src/priority_job_queue.sv */
`default_nettype none

// Bounded job queue held in descending priority order in a simple dual-port
// entry memory (one write and one registered read per cycle). An add walks
// from the tail toward the head, moving every entry of lower priority down one
// slot; on an empty queue it writes the new entry straight to the head. A pop
// reads the head and moves the rest up one slot. Searches and list-all read
// every held entry once, one per cycle, and stall only while the output
// register is still held by the consumer. Clear, a full add and a pop or
// search on an empty queue go straight to the result. o_ready is high only
// between items. Each result carries o_last on the final result of its item;
// func codes six and seven are accepted and dropped without a result.
// There is no clearing pass: entries past the occupancy count are never read.
module priority_job_queue
    import pjq_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    // request channel
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [2:0]         i_func,
    input  wire  [15:0]        i_job_tag,
    input  wire  [15:0]        i_user_tag,
    input  wire  [7:0]         i_cpu_count,
    input  wire  [7:0]         i_gpu_count,
    input  wire  [15:0]        i_memory_amount,
    input  wire  [23:0]        i_run_time,
    input  wire  signed [15:0] i_job_priority,
    // result channel
    output logic               o_valid,
    input  wire                i_ready,
    output logic [1:0]         o_status,
    output logic [15:0]        o_out_job_tag,
    output logic [15:0]        o_out_user_tag,
    output logic [7:0]         o_out_cpus,
    output logic [7:0]         o_out_gpus,
    output logic [15:0]        o_out_memory,
    output logic [23:0]        o_out_time,
    output logic signed [15:0] o_out_priority,
    output logic               o_last
);

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_occ, n_occ;          // number of held entries
    logic [CW-1:0]   r_idx, n_idx;          // walk position
    logic [NW-1:0]   r_cnt, n_cnt;          // matches found so far
    logic            r_have_pend, n_have_pend;
    logic            r_out_valid, n_out_valid;

    // payload
    t_entry          r_key, n_key;          // captured request fields
    t_func           r_func, n_func;
    t_entry          r_pend, n_pend;        // result held back until we know if it is last
    t_status         r_pend_st, n_pend_st;
    t_entry          r_out, n_out;
    t_status         r_out_st, n_out_st;
    logic            r_out_last, n_out_last;

    // entry memory
    t_entry          mem [QUEUE_DEPTH];
    t_entry          r_rd_data;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;

    t_entry          in_entry;
    t_match          match;
    logic            out_free;
    logic [CW-1:0]   idx_up, idx_dn, idx_dn2;
    logic [NW-1:0]   cnt_up, cnt_next;

    assign in_entry = '{job_tag:  i_job_tag,
                        user_tag: i_user_tag,
                        cpus:     i_cpu_count,
                        gpus:     i_gpu_count,
                        memory:   i_memory_amount,
                        run_time: i_run_time,
                        prio:     i_job_priority};

    // shared compare unit: match test for scans, priority order for adds
    pjq_match u_match (
        .i_entry (r_rd_data),
        .i_key   (r_key),
        .i_func  (r_func),
        .o_match (match)
    );

    assign out_free = !r_out_valid || i_ready;
    assign idx_up   = r_idx + CW'(1);
    assign idx_dn   = r_idx - CW'(1);
    assign idx_dn2  = r_idx - CW'(2);
    assign cnt_up   = r_cnt + NW'(1);
    assign cnt_next = match.hit ? cnt_up : r_cnt;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_key      <= n_key;
        r_func     <= n_func;
        r_pend     <= n_pend;
        r_pend_st  <= n_pend_st;
        r_out      <= n_out;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_have_pend = r_have_pend;
        n_key       = r_key;
        n_func      = r_func;
        n_pend      = r_pend;
        n_pend_st   = r_pend_st;
        n_out       = r_out;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wdata   = r_key;
        rd_addr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key       = in_entry;
                    n_func      = t_func'(i_func);
                    n_idx       = '0;
                    n_cnt       = '0;
                    n_have_pend = 1'b0;
                    unique case (t_func'(i_func))
                        FN_ADD: begin
                            if (r_occ == CW'(QUEUE_DEPTH)) begin
                                n_pend    = '0;
                                n_pend_st = ST_FULL;
                                n_state   = S_DONE;
                            end else if (r_occ == '0) begin
                                n_state = S_ADD_PUT;
                            end else begin
                                n_idx   = r_occ;
                                n_state = S_ADD_RD;
                            end
                        end
                        FN_POP: begin
                            if (r_occ == '0) begin
                                n_pend    = '0;
                                n_pend_st = ST_NONE;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        FN_USER, FN_CAP, FN_LIST: begin
                            if (r_occ == '0) begin
                                n_pend    = '0;
                                n_pend_st = ST_NONE;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        FN_CLEAR: begin
                            n_occ     = '0;
                            n_pend    = '0;
                            n_pend_st = ST_OK;
                            n_state   = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;   // unused code: dropped
                        end
                    endcase
                end
            end

            // insertion walk: tail toward head
            S_ADD_RD: begin
                rd_addr = idx_dn[AW-1:0];
                n_state = S_ADD_CMP;
            end
            S_ADD_CMP: begin
                if (match.lower) begin
                    // entry above has lower priority: move it down
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                    n_idx     = idx_dn;
                    if (idx_dn == '0) begin
                        n_state = S_ADD_PUT;
                    end else begin
                        rd_addr = idx_dn2[AW-1:0];
                    end
                end else begin
                    mem_we    = 1'b1;
                    n_occ     = r_occ + CW'(1);
                    n_pend    = r_key;
                    n_pend_st = ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_ADD_PUT: begin
                mem_we    = 1'b1;
                n_occ     = r_occ + CW'(1);
                n_pend    = r_key;
                n_pend_st = ST_OK;
                n_state   = S_DONE;
            end

            // pop: read head, then move the rest up one slot
            S_POP_RD: begin
                rd_addr = '0;
                n_state = S_POP_HEAD;
            end
            S_POP_HEAD: begin
                n_pend    = r_rd_data;
                n_pend_st = ST_OK;
                if (r_occ == CW'(1)) begin
                    n_occ   = r_occ - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = CW'(1);
                    rd_addr = AW'(1);
                    n_state = S_POP_SH;
                end
            end
            S_POP_SH: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dn[AW-1:0];
                mem_wdata = r_rd_data;
                n_idx     = idx_up;
                if (idx_up < r_occ) begin
                    rd_addr = idx_up[AW-1:0];
                end else begin
                    n_occ   = r_occ - CW'(1);
                    n_state = S_DONE;
                end
            end

            // search / list: one entry per cycle unless stalled on the output, one match held back
            S_SCAN_RD: begin
                rd_addr = r_idx[AW-1:0];
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (match.hit && r_have_pend && !out_free) begin
                    rd_addr = r_idx[AW-1:0];    // hold read data while stalled
                end else begin
                    if (match.hit) begin
                        if (r_have_pend) begin
                            n_out       = r_pend;
                            n_out_st    = ST_OK;
                            n_out_last  = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        n_pend      = r_rd_data;
                        n_pend_st   = ST_OK;
                        n_have_pend = 1'b1;
                        n_cnt       = cnt_up;
                    end
                    n_idx = idx_up;
                    if (idx_up < r_occ && cnt_next < NW'(MAX_RESULTS)) begin
                        rd_addr = idx_up[AW-1:0];
                    end else begin
                        n_state = S_DONE;
                        if (!(match.hit || r_have_pend)) begin
                            n_pend    = '0;
                            n_pend_st = ST_NONE;
                        end
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_st    = r_pend_st;
                    n_out_last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_st;
    assign o_out_job_tag  = r_out.job_tag;
    assign o_out_user_tag = r_out.user_tag;
    assign o_out_cpus     = r_out.cpus;
    assign o_out_gpus     = r_out.gpus;
    assign o_out_memory   = r_out.memory;
    assign o_out_time     = r_out.run_time;
    assign o_out_priority = r_out.prio;
    assign o_last         = r_out_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != $past(r_occ)) |-> (r_occ == $past(r_occ) + CW'(1)
                                  || r_occ == $past(r_occ) - CW'(1)
                                  || r_occ == '0))
        else $error("occupancy moved by more than one entry");

    a_not_last_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> r_have_pend)
        else $error("non-final result with no result held behind it");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_idx < r_occ))
        else $error("scan past occupied entries");

endmodule

`default_nettype wire

/* bench/priority_job_queue_tb.sv */
`timescale 1ns / 1ps

module priority_job_queue_tb;
    import pjq_pkg::*;

    // Spare func codes: accepted by the block, dropped without a result.
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;   // one full-queue operation plus margin
    localparam int PRINT_CAP   = 50;

    // One request as driven on the input channel.
    typedef struct packed {
        logic [2:0] func;
        t_entry     ent;
    } job_request_t;

    // One result as expected on the output channel.
    typedef struct packed {
        t_status status;
        t_entry  ent;
        logic    last;
    } job_result_t;

    logic               i_clk;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    job_request_t       req_drv = '0;
    logic               rsp_ready = 1'b0;
    logic               req_taken = 1'b0;

    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [15:0]        o_out_job_tag;
    logic [15:0]        o_out_user_tag;
    logic [7:0]         o_out_cpus;
    logic [7:0]         o_out_gpus;
    logic [15:0]        o_out_memory;
    logic [23:0]        o_out_time;
    logic signed [15:0] o_out_priority;
    logic               o_last;

    // Stimulus backlog, shadow queue contents and results still owed.
    job_request_t       job_backlog [$];
    t_entry             shadow_jobs [QUEUE_DEPTH];
    int                 shadow_count = 0;
    job_result_t        awaited_results [$];

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;

    // Small pools of users and resource sets so searches actually hit.
    logic [15:0]        user_pool [4];
    t_entry             res_pool [4];

    priority_job_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_ready         (o_ready),
        .i_func          (req_drv.func),
        .i_job_tag       (req_drv.ent.job_tag),
        .i_user_tag      (req_drv.ent.user_tag),
        .i_cpu_count     (req_drv.ent.cpus),
        .i_gpu_count     (req_drv.ent.gpus),
        .i_memory_amount (req_drv.ent.memory),
        .i_run_time      (req_drv.ent.run_time),
        .i_job_priority  (req_drv.ent.prio),
        .o_valid         (o_valid),
        .i_ready         (rsp_ready),
        .o_status        (o_status),
        .o_out_job_tag   (o_out_job_tag),
        .o_out_user_tag  (o_out_user_tag),
        .o_out_cpus      (o_out_cpus),
        .o_out_gpus      (o_out_gpus),
        .o_out_memory    (o_out_memory),
        .o_out_time      (o_out_time),
        .o_out_priority  (o_out_priority),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        if (fail_count < PRINT_CAP)
            $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
            note_mismatch($sformatf("%s got %0h want %0h", name, got_v, want_v));
    endtask

    // ------------------------------------------------------------------
    // Shadow queue: applies one accepted request, queues the results owed
    // ------------------------------------------------------------------
    function automatic job_result_t blank_result(input t_status s);
        job_result_t r;
        r = '0;
        r.status = s;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void serve_request(input job_request_t rq);
        t_entry found [$];
        int     pos;
        int     i;
        logic   hit;
        case (rq.func)
            FN_ADD: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    awaited_results.push_back(blank_result(ST_FULL));
                end else begin
                    // new job goes behind every job of greater or equal priority
                    pos = 0;
                    while (pos < shadow_count && shadow_jobs[pos].prio >= rq.ent.prio)
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                        shadow_jobs[i] = shadow_jobs[i - 1];
                    shadow_jobs[pos] = rq.ent;
                    shadow_count++;
                    awaited_results.push_back('{status: ST_OK, ent: rq.ent, last: 1'b1});
                end
            end
            FN_POP: begin
                if (shadow_count == 0) begin
                    awaited_results.push_back(blank_result(ST_NONE));
                end else begin
                    awaited_results.push_back('{status: ST_OK, ent: shadow_jobs[0],
                                                last: 1'b1});
                    for (i = 1; i < shadow_count; i++)
                        shadow_jobs[i - 1] = shadow_jobs[i];
                    shadow_count--;
                end
            end
            FN_USER, FN_CAP, FN_LIST: begin
                for (i = 0; i < shadow_count && found.size() < MAX_RESULTS; i++) begin
                    hit = 1'b1;
                    if (rq.func == FN_USER)
                        hit = shadow_jobs[i].user_tag == rq.ent.user_tag;
                    else if (rq.func == FN_CAP)
                        hit = shadow_jobs[i].cpus == rq.ent.cpus
                           && shadow_jobs[i].gpus == rq.ent.gpus
                           && shadow_jobs[i].memory == rq.ent.memory
                           && shadow_jobs[i].run_time == rq.ent.run_time;
                    if (hit)
                        found.push_back(shadow_jobs[i]);
                end
                if (found.size() == 0) begin
                    awaited_results.push_back(blank_result(ST_NONE));
                end else begin
                    foreach (found[k])
                        awaited_results.push_back('{status: ST_OK, ent: found[k],
                                                    last: (k == found.size() - 1)});
                end
            end
            FN_CLEAR: begin
                shadow_count = 0;
                awaited_results.push_back(blank_result(ST_OK));
            end
            default: ;  // spare codes: no result, no state change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge only. Valid holds with a
    // stable payload until the item has been taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rst_n && (!req_valid || req_taken)) begin
            if (job_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req_drv   <= job_backlog.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
        rsp_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. Prediction comes
    // first, though a result never shares an edge with its own request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        job_result_t want;
        req_taken <= rst_n && req_valid && o_ready;
        if (rst_n && req_valid && o_ready)
            serve_request(req_drv);
        if (rst_n && o_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing awaited, status %0h",
                                        o_status));
            end else begin
                want = awaited_results.pop_front();
                check_field("status",       32'(o_status),       32'(want.status));
                check_field("out_job_tag",  32'(o_out_job_tag),  32'(want.ent.job_tag));
                check_field("out_user_tag", 32'(o_out_user_tag), 32'(want.ent.user_tag));
                check_field("out_cpus",     32'(o_out_cpus),     32'(want.ent.cpus));
                check_field("out_gpus",     32'(o_out_gpus),     32'(want.ent.gpus));
                check_field("out_memory",   32'(o_out_memory),   32'(want.ent.memory));
                check_field("out_time",     32'(o_out_time),     32'(want.ent.run_time));
                check_field("out_priority", 32'(o_out_priority), 32'(want.ent.prio));
                check_field("last",         32'(o_last),         32'(want.last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("priority_job_queue: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_job(input logic [2:0] fn, input logic [15:0] job,
                            input logic [15:0] user, input logic [7:0] cpus,
                            input logic [7:0] gpus, input logic [15:0] mem,
                            input logic [23:0] run, input logic [15:0] prio);
        job_request_t rq;
        rq.func = fn;
        rq.ent.job_tag  = job;
        rq.ent.user_tag = user;
        rq.ent.cpus     = cpus;
        rq.ent.gpus     = gpus;
        rq.ent.memory   = mem;
        rq.ent.run_time = run;
        rq.ent.prio     = prio;
        job_backlog.push_back(rq);
    endtask

    // Full-range random payload, then biased toward pooled users, pooled
    // resource sets and clustered priorities so ties and hits are common.
    function automatic job_request_t random_job(input logic [2:0] fn);
        job_request_t rq;
        int           sel;
        rq.func         = fn;
        rq.ent.job_tag  = 16'($urandom_range(0, 65535));
        rq.ent.user_tag = 16'($urandom_range(0, 65535));
        rq.ent.cpus     = 8'($urandom_range(0, 255));
        rq.ent.gpus     = 8'($urandom_range(0, 255));
        rq.ent.memory   = 16'($urandom_range(0, 65535));
        rq.ent.run_time = 24'($urandom_range(0, 24'hFFFFFF));
        rq.ent.prio     = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 70)
            rq.ent.user_tag = user_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 99) < 65) begin
            sel = $urandom_range(0, 3);
            rq.ent.cpus     = res_pool[sel].cpus;
            rq.ent.gpus     = res_pool[sel].gpus;
            rq.ent.memory   = res_pool[sel].memory;
            rq.ent.run_time = res_pool[sel].run_time;
        end
        sel = $urandom_range(0, 99);
        if (sel < 45)
            rq.ent.prio = 16'($signed($urandom_range(0, 4)) - 2);
        else if (sel < 60)
            rq.ent.prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return rq;
    endfunction

    // Random mix, mostly adds so the queue fills up. Spare codes are sprinkled
    // in but not counted.
    task automatic queue_random_jobs(input int count);
        int          done;
        int          r;
        logic [2:0]  fn;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 42)      fn = FN_ADD;
            else if (r < 57) fn = FN_POP;
            else if (r < 69) fn = FN_USER;
            else if (r < 81) fn = FN_CAP;
            else if (r < 89) fn = FN_LIST;
            else if (r < 92) fn = FN_CLEAR;
            else             fn = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
            job_backlog.push_back(random_job(fn));
            if (fn != FN_SPARE_LO && fn != FN_SPARE_HI)
                done++;
        end
    endtask

    // Sender fully drained and every owed result delivered.
    task automatic wait_drained;
        do begin
            @(posedge i_clk);
            #1;
        end while (job_backlog.size() != 0 || req_valid || awaited_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int i;
        user_pool[0] = 16'h0000;
        user_pool[1] = 16'hFFFF;
        user_pool[2] = 16'($urandom_range(0, 65535));
        user_pool[3] = 16'($urandom_range(0, 65535));
        res_pool[0] = '0;
        res_pool[1] = '1;
        for (i = 2; i < 4; i++) begin
            res_pool[i] = '0;
            res_pool[i].cpus     = 8'($urandom_range(0, 255));
            res_pool[i].gpus     = 8'($urandom_range(0, 255));
            res_pool[i].memory   = 16'($urandom_range(0, 65535));
            res_pool[i].run_time = 24'($urandom_range(0, 24'hFFFFFF));
        end

        repeat (3) @(negedge i_clk);
        rst_n = 1'b1;

        // Phase one: sender rarely idle, receiver often stalled.
        send_idle_pct = 11;
        recv_idle_pct = 49;

        // pop, searches and list on an empty queue
        push_job(FN_POP,  16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_USER, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_CAP,  16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_LIST, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        // ties keep arrival order; priority extremes; all-ones and all-zero jobs
        push_job(FN_ADD, 16'h0001, 16'h00A1, 8'd4, 8'd1, 16'd1024, 24'd360000, 16'sd0);
        push_job(FN_ADD, 16'h0002, 16'h00A2, 8'd4, 8'd1, 16'd1024, 24'd360000, 16'sd0);
        push_job(FN_ADD, 16'h0003, 16'h00A1, 8'd8, 8'd0, 16'd2048, 24'd100, 16'sh7FFF);
        push_job(FN_ADD, 16'h0004, 16'h00A3, 8'd1, 8'd0, 16'd512, 24'd50, 16'sh8000);
        push_job(FN_ADD, 16'h0005, 16'h00A2, 8'd4, 8'd1, 16'd1024, 24'd360000, 16'sd0);
        push_job(FN_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF,
                 16'sh7FFF);
        push_job(FN_ADD, 16'h0000, 16'h0000, 8'h0, 8'h0, 16'h0, 24'h0, 16'sd0);
        push_job(FN_LIST, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        // search hits and misses
        push_job(FN_USER, 16'h0, 16'h00A1, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_USER, 16'h0, 16'h1234, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_CAP, 16'h0, 16'h0, 8'd4, 8'd1, 16'd1024, 24'd360000, 16'h0);
        push_job(FN_CAP, 16'h0, 16'h0, 8'd4, 8'd1, 16'd1024, 24'd360001, 16'h0);
        push_job(FN_POP, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_POP, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        // spare codes are dropped silently
        push_job(FN_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF,
                 16'hFFFF);
        push_job(FN_SPARE_HI, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF,
                 16'hFFFF);
        // clear, then the queue must look empty again
        push_job(FN_CLEAR, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_LIST,  16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);
        push_job(FN_POP,   16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 16'h0);

        // Fill to capacity, overflow twice, then stream the full queue.
        job_backlog.push_back(random_job(FN_CLEAR));
        for (i = 0; i < QUEUE_DEPTH + 2; i++)
            job_backlog.push_back(random_job(FN_ADD));
        job_backlog.push_back(random_job(FN_LIST));
        job_backlog.push_back(random_job(FN_USER));
        job_backlog.push_back(random_job(FN_CAP));
        queue_random_jobs(20);

        // Sender holds off until every owed result is in.
        wait_drained();

        // Phase two: sender often idle, receiver rarely stalled.
        send_idle_pct = 49;
        recv_idle_pct = 11;
        queue_random_jobs(40);
        wait_drained();

        // Phase three: back-to-back, no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_jobs(30);
        wait_drained();

        // let any stray result show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        #1;
        if (awaited_results.size() != 0)
            note_mismatch($sformatf("%0d results never delivered",
                                    awaited_results.size()));

        if (fail_count == 0) begin
            $display("priority_job_queue: match");
        end else begin
            $display("priority_job_queue: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/pjq_pkg.sv
src/pjq_match.sv
src/priority_job_queue.sv
bench/priority_job_queue_tb.sv
